FILE: rtl/ilid_pkg.sv
// ----------------------------------------------------------------------------
// ilid_pkg - shared types for the indexed list engine
// Command, status and cell operation codes, and the fixed field widths.
// ----------------------------------------------------------------------------
`default_nettype none

package ilid_pkg;

    localparam int POS_W   = 6;
    localparam int WORD_W  = 32;
    localparam int COUNT_W = 7;
    localparam int WIDE_W  = 64;   // widest supported data word

    localparam int DEPTH_DEFAULT      = 64;
    localparam int DATA_WIDTH_DEFAULT = 32;

    typedef enum logic [1:0] {
        CMD_APPEND = 2'd0,
        CMD_INSERT = 2'd1,
        CMD_DELETE = 2'd2,
        CMD_READ   = 2'd3
    } ilid_cmd_t;

    typedef enum logic [1:0] {
        ST_OK   = 2'd0,
        ST_OOB  = 2'd1,
        ST_FULL = 2'd2
    } ilid_status_t;

    // What one cell does on the next edge
    typedef enum logic [1:0] {
        OP_HOLD  = 2'd0,
        OP_LOAD  = 2'd1,
        OP_LEFT  = 2'd2,   // take lower neighbor (insert shift up)
        OP_RIGHT = 2'd3    // take upper neighbor (delete shift down)
    } ilid_op_t;

endpackage

`default_nettype wire

FILE: rtl/ilid_if.sv
// ----------------------------------------------------------------------------
// ilid_if - request and response channels of the indexed list engine
// Valid/ready handshake; a request moves when valid and ready are both high.
// ----------------------------------------------------------------------------
`default_nettype none

interface ilid_req_if;
    logic                          valid;
    logic                          ready;
    ilid_pkg::ilid_cmd_t           command;
    logic [ilid_pkg::POS_W-1:0]    position;
    logic [ilid_pkg::WORD_W-1:0]   value;

    modport source (output valid, output command, output position, output value,
                    input ready);
    modport sink   (input valid, input command, input position, input value,
                    output ready);
endinterface

interface ilid_rsp_if;
    logic                          valid;
    logic                          ready;
    logic [ilid_pkg::WORD_W-1:0]   read_value;
    ilid_pkg::ilid_status_t        status;
    logic [ilid_pkg::COUNT_W-1:0]  count;

    modport source (output valid, output read_value, output status, output count,
                    input ready);
    modport sink   (input valid, input read_value, input status, input count,
                    output ready);
endinterface

`default_nettype wire

FILE: rtl/indexed_list_insert_delete.sv
// ----------------------------------------------------------------------------
// indexed_list_insert_delete - ordered word list with insert and delete
// Shift-register list: a row of DEPTH cells; cells below the edit point hold.
// ----------------------------------------------------------------------------
// Usage:
//   req carries one command per request: append, insert at position,
//   delete at position, or read at position. rsp returns one response per
//   request with the read word (zero unless a read hit), a status
//   (ok, out of bounds, full) and the entry count after the command.
// Timing:
//   The response is registered and appears in the cycle after the request
//   is taken. Every command, insert and delete included, is done at once:
//   each cell picks its own word, its neighbor's, or the new word in
//   parallel, so one request per cycle is sustained unless rsp stalls.
// Stall:
//   A single response register sits on rsp. req.ready is high while that
//   register is empty or being drained this cycle, so a stalled receiver
//   stops new requests after one is held and none is lost.
// Reset:
//   rst_n clears the count and the response valid. Cell contents are not
//   cleared; slots at or beyond the count are never read.
// ----------------------------------------------------------------------------
`default_nettype none

module indexed_list_insert_delete #(
    parameter int DEPTH      = ilid_pkg::DEPTH_DEFAULT,
    parameter int DATA_WIDTH = ilid_pkg::DATA_WIDTH_DEFAULT
) (
    input  wire logic  clk,
    input  wire logic  rst_n,
    ilid_req_if.sink   req,
    ilid_rsp_if.source rsp
);

    localparam int FW = $clog2(DEPTH + 1);          // count width
    localparam int CW = FW + ilid_pkg::POS_W;       // compare width

    // ---------------- list state ----------------
    logic [FW-1:0] fill_reg;
    logic [FW-1:0] fill_next;

    // ---------------- response register ----------------
    logic                                rsp_valid_reg;
    logic [ilid_pkg::WORD_W-1:0]         rd_reg;
    logic [ilid_pkg::WORD_W-1:0]         rd_next;
    ilid_pkg::ilid_status_t              st_reg;
    ilid_pkg::ilid_status_t              st_next;
    logic [ilid_pkg::COUNT_W-1:0]        cnt_reg;

    logic accept;
    logic full;
    logic ins_ok;
    logic del_ok;
    logic rd_hit;

    logic [CW-1:0] posx;
    logic [CW-1:0] fillx;
    logic [CW-1:0] tgt;

    logic [ilid_pkg::WIDE_W-1:0]  val_wide;
    logic [DATA_WIDTH-1:0]        load_word;
    logic [DATA_WIDTH-1:0]        rd_sel;
    logic [ilid_pkg::WIDE_W-1:0]  rd_wide;
    logic [CW-1:0]                fill_next_wide;

    logic [DATA_WIDTH-1:0] cell_q   [DEPTH];
    logic [DATA_WIDTH-1:0] cell_hit [DEPTH];
    ilid_pkg::ilid_op_t    cell_op  [DEPTH];

    // Take a request while the response slot is free or draining now
    assign req.ready = !rsp_valid_reg || rsp.ready;
    assign accept    = req.valid && req.ready;

    assign posx  = CW'(req.position);
    assign fillx = CW'(fill_reg);
    assign full  = (fill_reg == FW'(DEPTH));

    // Input word cut or zero-extended to the storage width
    assign val_wide  = ilid_pkg::WIDE_W'(req.value);
    assign load_word = val_wide[DATA_WIDTH-1:0];

    // ---------------- command decode ----------------
    always_comb
    begin
        st_next = ilid_pkg::ST_OK;
        ins_ok  = 1'b0;
        del_ok  = 1'b0;
        rd_hit  = 1'b0;
        tgt     = posx;
        case (req.command)
            ilid_pkg::CMD_APPEND:
            begin
                tgt = fillx;
                if (full)
                    st_next = ilid_pkg::ST_FULL;
                else
                    ins_ok = 1'b1;
            end
            ilid_pkg::CMD_INSERT:
            begin
                // bounds checked before fullness
                if (posx > fillx)
                    st_next = ilid_pkg::ST_OOB;
                else if (full)
                    st_next = ilid_pkg::ST_FULL;
                else
                    ins_ok = 1'b1;
            end
            ilid_pkg::CMD_DELETE:
            begin
                if (posx >= fillx)
                    st_next = ilid_pkg::ST_OOB;
                else
                    del_ok = 1'b1;
            end
            ilid_pkg::CMD_READ:
            begin
                if (posx >= fillx)
                    st_next = ilid_pkg::ST_OOB;
                else
                    rd_hit = 1'b1;
            end
            default:
            begin
                st_next = ilid_pkg::ST_OOB;
            end
        endcase
    end

    always_comb
    begin
        fill_next = fill_reg;
        if (accept && ins_ok)
            fill_next = fill_reg + FW'(1);
        else if (accept && del_ok)
            fill_next = fill_reg - FW'(1);
    end

    // ---------------- cell row ----------------
    // Each slot works out its own move from its index against the target.
    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        logic [DATA_WIDTH-1:0] left_w;
        logic [DATA_WIDTH-1:0] right_w;

        if (i == 0)
        begin : g_first
            assign left_w = '0;
        end
        else
        begin : g_left
            assign left_w = cell_q[i-1];
        end

        if (i == DEPTH - 1)
        begin : g_last
            assign right_w = '0;
        end
        else
        begin : g_right
            assign right_w = cell_q[i+1];
        end

        always_comb
        begin
            cell_op[i] = ilid_pkg::OP_HOLD;
            if (accept && ins_ok)
            begin
                if (CW'(i) == tgt)
                    cell_op[i] = ilid_pkg::OP_LOAD;
                else if (CW'(i) > tgt)
                    cell_op[i] = ilid_pkg::OP_LEFT;
            end
            else if (accept && del_ok)
            begin
                if (CW'(i) >= posx)
                    cell_op[i] = ilid_pkg::OP_RIGHT;
            end
        end

        // read select: only the addressed slot passes its word
        assign cell_hit[i] = (CW'(i) == posx) ? cell_q[i] : '0;

        ilid_cell #(
            .DATA_WIDTH (DATA_WIDTH)
        ) u_cell (
            .clk        (clk),
            .op         (cell_op[i]),
            .load_data  (load_word),
            .left_data  (left_w),
            .right_data (right_w),
            .data       (cell_q[i])
        );
    end

    always_comb
    begin
        rd_sel = '0;
        for (int k = 0; k < DEPTH; k++)
            rd_sel = rd_sel | cell_hit[k];
    end

    assign rd_wide        = ilid_pkg::WIDE_W'(rd_sel);
    assign rd_next        = rd_hit ? rd_wide[ilid_pkg::WORD_W-1:0] : '0;
    assign fill_next_wide = CW'(fill_next);

    // ---------------- control registers ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg      <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            fill_reg <= fill_next;
            if (accept)
                rsp_valid_reg <= 1'b1;
            else if (rsp.ready)
                rsp_valid_reg <= 1'b0;
        end
    end

    // ---------------- response payload ----------------
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            rd_reg  <= rd_next;
            st_reg  <= st_next;
            cnt_reg <= fill_next_wide[ilid_pkg::COUNT_W-1:0];
        end
    end

    assign rsp.valid      = rsp_valid_reg;
    assign rsp.read_value = rd_reg;
    assign rsp.status     = st_reg;
    assign rsp.count      = cnt_reg;

endmodule

`default_nettype wire

FILE: rtl/ilid_cell.sv
// ----------------------------------------------------------------------------
// ilid_cell - one list slot
// Holds one word; loads, holds, or takes a neighbor's word each cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module ilid_cell #(
    parameter int DATA_WIDTH = ilid_pkg::DATA_WIDTH_DEFAULT
) (
    input  wire logic                  clk,
    input  wire ilid_pkg::ilid_op_t    op,
    input  wire logic [DATA_WIDTH-1:0] load_data,
    input  wire logic [DATA_WIDTH-1:0] left_data,
    input  wire logic [DATA_WIDTH-1:0] right_data,
    output logic      [DATA_WIDTH-1:0] data
);

    logic [DATA_WIDTH-1:0] data_reg;
    logic [DATA_WIDTH-1:0] data_next;

    always_comb
    begin
        case (op)
            ilid_pkg::OP_LOAD:  data_next = load_data;
            ilid_pkg::OP_LEFT:  data_next = left_data;
            ilid_pkg::OP_RIGHT: data_next = right_data;
            default:            data_next = data_reg;
        endcase
    end

    // payload only, no reset
    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign data = data_reg;

endmodule

`default_nettype wire
